/* rtl/vna_pkg.sv */
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Command codes and fixed field widths shared by the accumulator design.
// ----------------------------------------------------------------------------
package vna_pkg;

  // Command codes carried by the command field of an input word.
  localparam logic [1:0] CMD_STORE = 2'd0;
  localparam logic [1:0] CMD_TRI   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Fixed field widths.
  localparam int unsigned IDX_W = 10;
  localparam int unsigned POS_W = 16;
  localparam int unsigned NRM_W = 16;
  localparam int unsigned SUM_W = 24;

  // Edge vectors need one bit more than a coordinate.
  localparam int unsigned EDGE_W = POS_W + 1;

  // Cross product components fit in this signed width.
  localparam int unsigned CRS_W = 2 * EDGE_W + 1;

  // Width of an index compare that holds the largest vertex count.
  localparam int unsigned LIM_W = 17;

endpackage

/* rtl/vertex_normal_accumulator.sv */
// ----------------------------------------------------------------------------
// Vertex normal accumulator
// Stores mesh positions, accumulates unit face normals per vertex and returns
// normalized smooth vertex normals in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o) takes one word per command.
//   A store word writes a position and clears that vertex's sum in the cycle it is accepted.
//   A triangle word whose corners all lie below VERTICES reads three positions,
//   forms the cross product on one shared multiplier, normalizes it (one-bit
//   shift steps, a digit-serial square root and a bit-serial divider) and
//   read-modify-writes three sums; a zero cross product leaves them unchanged.
//   Store and triangle words with an index out of range are dropped.
//   A read word loads one sum and, unless it is zero, runs the same normalizer
//   before it returns one word on the output channel (out_valid_o / out_ready_i).
//   A zero sum or an index out of range gives a zero word with zero_sum_o set.
//   Latency and throughput are set by the shared multiplier, the square root
//   loop and the divider; one word is in work at a time.
//   A finished result waits in the output register; the block takes new
//   words while it waits and stalls only when a second result is ready.
//   After reset the block sweeps every entry of the sum memory to zero
//   and holds in_ready_o low meanwhile. Positions are undefined until stored.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator
  import vna_pkg::*;
#(
  parameter int unsigned VERTICES  = 1024,
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              command_i,
  input  logic [IDX_W-1:0]        vertex_index_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  input  logic [IDX_W-1:0]        corner_a_i,
  input  logic [IDX_W-1:0]        corner_b_i,
  input  logic [IDX_W-1:0]        corner_c_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [NRM_W-1:0] normal_x_o,
  output logic signed [NRM_W-1:0] normal_y_o,
  output logic signed [NRM_W-1:0] normal_z_o,
  output logic                    zero_sum_o
);

  // Derived widths.
  localparam int unsigned AW    = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned P     = FRAC_BITS + 8;
  localparam int unsigned MW    = P + 1;
  localparam int unsigned PW    = 2 * MW;
  localparam int unsigned LW    = 2 * P + 2;
  localparam int unsigned MAGW  = (P > CRS_W - 1) ? P : CRS_W - 1;
  localparam int unsigned RTW   = P + 1;
  localparam int unsigned SRW   = P + 3;
  localparam int unsigned DRW   = P + 2;
  localparam int unsigned NW    = P + F + 1;
  localparam int unsigned QW    = F + 1;
  localparam int unsigned RESW  = F + 2;
  localparam int unsigned TW    = (F + 3 > SUM_W + 1) ? F + 3 : SUM_W + 1;
  localparam int unsigned CNTW  = $clog2(P + 2);
  localparam int unsigned PMW   = 3 * POS_W;
  localparam int unsigned SMW   = 3 * SUM_W;
  localparam logic [LIM_W-1:0] VLIM = LIM_W'(VERTICES);

  // Sequencer states.
  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_POS    = 4'd2;
  localparam logic [3:0] ST_CROSS  = 4'd3;
  localparam logic [3:0] ST_SIGN   = 4'd4;
  localparam logic [3:0] ST_NORM   = 4'd5;
  localparam logic [3:0] ST_SQ     = 4'd6;
  localparam logic [3:0] ST_SQRT   = 4'd7;
  localparam logic [3:0] ST_DIVI   = 4'd8;
  localparam logic [3:0] ST_DIV    = 4'd9;
  localparam logic [3:0] ST_RMW_RD = 4'd10;
  localparam logic [3:0] ST_RMW_WR = 4'd11;
  localparam logic [3:0] ST_SUM_RD = 4'd12;
  localparam logic [3:0] ST_SUM_LD = 4'd13;
  localparam logic [3:0] ST_OUT    = 4'd14;

  // Saturating add of a unit component onto a 24-bit sum.
  function automatic logic [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                input logic signed [RESW-1:0]  v);
    logic signed [TW-1:0] t;
    logic [SUM_W-1:0]     r;
    t = TW'(s) + TW'(v);
    if (t[TW-1:SUM_W-1] != {(TW-SUM_W+1){t[TW-1]}}) begin
      r = t[TW-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = t[SUM_W-1:0];
    end
    return r;
  endfunction

  // Magnitude of a stored sum.
  function automatic logic [MAGW-1:0] sum_mag(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W:0] se;
    se = (SUM_W+1)'(s);
    return MAGW'($unsigned(s[SUM_W-1] ? -se : se));
  endfunction

  // Magnitude of a cross product component.
  function automatic logic [MAGW-1:0] crs_mag(input logic signed [CRS_W-1:0] c);
    return MAGW'($unsigned(c[CRS_W-1] ? -c : c));
  endfunction

  // Control registers.
  logic [3:0]      state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [1:0]      comp_q, comp_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic            out_valid_q, out_valid_d;

  // Datapath registers.
  logic [AW-1:0]              cor_q [3];
  logic [AW-1:0]              vidx_q;
  logic                       is_tri_q;
  logic                       zf_q;
  logic signed [POS_W-1:0]    pa_q [3];
  logic signed [EDGE_W-1:0]   e1_q [3];
  logic signed [EDGE_W-1:0]   e2_q [3];
  logic signed [CRS_W-1:0]    c_q [3];
  logic [MAGW-1:0]            mag_q [3];
  logic                       sgn_q [3];
  logic signed [PW-1:0]       prod_q;
  logic [LW-1:0]              rad_q;
  logic [SRW-1:0]             sq_rem_q;
  logic [RTW-1:0]             root_q;
  logic [DRW-1:0]             div_rem_q;
  logic [QW-1:0]              nlo_q;
  logic [QW-1:0]              quo_q;
  logic signed [RESW-1:0]     res_q [3];
  logic signed [NRM_W-1:0]    nx_q, ny_q, nz_q;
  logic                       zs_q;

  // Memories and their ports.
  logic [PMW-1:0] pos_mem [VERTICES];
  logic [SMW-1:0] sum_mem [VERTICES];
  logic [PMW-1:0] pos_rd_q;
  logic [SMW-1:0] sum_rd_q;
  logic           pos_we, sum_we;
  logic [AW-1:0]  pos_waddr, pos_raddr, sum_waddr, sum_raddr;
  logic [SMW-1:0] sum_wdata;

  // Shared multiplier operands.
  logic signed [MW-1:0] mul_a, mul_b;

  // Decode of the input word.
  logic accept;
  logic vi_ok, ca_ok, cb_ok, cc_ok;

  // Combinational helpers.
  logic [MAGW-1:0] mag_or;
  logic            norm_hi, norm_lo;
  logic [SRW-1:0]  sq_rem_n, sq_trial;
  logic            sq_take;
  logic [DRW-1:0]  div_rem_n;
  logic            div_take;
  logic [QW-1:0]   quo_n;
  logic [NW-1:0]   numer;
  logic [MAGW-1:0] div_mag;
  logic [CNTW-1:0] cnt_prev;

  assign accept = in_valid_i && in_ready_o;
  assign vi_ok  = LIM_W'(vertex_index_i) < VLIM;
  assign ca_ok  = LIM_W'(corner_a_i) < VLIM;
  assign cb_ok  = LIM_W'(corner_b_i) < VLIM;
  assign cc_ok  = LIM_W'(corner_c_i) < VLIM;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign normal_x_o  = nx_q;
  assign normal_y_o  = ny_q;
  assign normal_z_o  = nz_q;
  assign zero_sum_o  = zs_q;

  // Normalizing shift decision on the largest magnitude.
  assign mag_or  = mag_q[0] | mag_q[1] | mag_q[2];
  assign norm_hi = |(mag_or >> P);
  assign norm_lo = !mag_or[P-1];

  // One digit of the square root.
  assign sq_rem_n = {sq_rem_q[SRW-3:0], rad_q[LW-1:LW-2]};
  assign sq_trial = {root_q, 2'b01};
  assign sq_take  = sq_rem_n >= sq_trial;

  // One bit of the divider.
  assign div_rem_n = {div_rem_q[DRW-2:0], nlo_q[QW-1]};
  assign div_take  = div_rem_n >= DRW'(root_q);
  assign quo_n     = {quo_q[QW-2:0], div_take};

  // Rounded dividend for the current component.
  always_comb begin
    case (comp_q)
      2'd0:    div_mag = mag_q[0];
      2'd1:    div_mag = mag_q[1];
      default: div_mag = mag_q[2];
    endcase
    numer = NW'({div_mag[P-1:0], {F{1'b0}}}) + NW'(root_q >> 1);
  end

  assign cnt_prev = cnt_q - CNTW'(1);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_CROSS: begin
        case (cnt_q)
          CNTW'(0): begin mul_a = MW'(e1_q[1]); mul_b = MW'(e2_q[2]); end
          CNTW'(1): begin mul_a = MW'(e1_q[2]); mul_b = MW'(e2_q[1]); end
          CNTW'(2): begin mul_a = MW'(e1_q[2]); mul_b = MW'(e2_q[0]); end
          CNTW'(3): begin mul_a = MW'(e1_q[0]); mul_b = MW'(e2_q[2]); end
          CNTW'(4): begin mul_a = MW'(e1_q[0]); mul_b = MW'(e2_q[1]); end
          CNTW'(5): begin mul_a = MW'(e1_q[1]); mul_b = MW'(e2_q[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_SQ: begin
        case (cnt_q)
          CNTW'(0): mul_a = $signed({1'b0, mag_q[0][P-1:0]});
          CNTW'(1): mul_a = $signed({1'b0, mag_q[1][P-1:0]});
          CNTW'(2): mul_a = $signed({1'b0, mag_q[2][P-1:0]});
          default:  mul_a = '0;
        endcase
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Memory port selection.
  always_comb begin
    pos_we    = 1'b0;
    pos_waddr = AW'(vertex_index_i);
    sum_we    = 1'b0;
    sum_waddr = AW'(vertex_index_i);
    sum_wdata = '0;
    case (cnt_q)
      CNTW'(0): pos_raddr = cor_q[0];
      CNTW'(1): pos_raddr = cor_q[1];
      default:  pos_raddr = cor_q[2];
    endcase
    if (state_q == ST_SUM_RD) begin
      sum_raddr = vidx_q;
    end else begin
      case (comp_q)
        2'd0:    sum_raddr = cor_q[0];
        2'd1:    sum_raddr = cor_q[1];
        default: sum_raddr = cor_q[2];
      endcase
    end
    case (state_q)
      ST_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_q;
      end
      ST_IDLE: begin
        if (accept && command_i == CMD_STORE && vi_ok) begin
          pos_we = 1'b1;
          sum_we = 1'b1;
        end
      end
      ST_RMW_WR: begin
        sum_we    = 1'b1;
        sum_waddr = sum_raddr;
        sum_wdata = {sat_add(sum_rd_q[3*SUM_W-1:2*SUM_W], res_q[0]),
                     sat_add(sum_rd_q[2*SUM_W-1:SUM_W], res_q[1]),
                     sat_add(sum_rd_q[SUM_W-1:0], res_q[2])};
      end
      default: begin
        sum_we = 1'b0;
      end
    endcase
  end

  // Position memory.
  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= {pos_x_i, pos_y_i, pos_z_i};
    end
    pos_rd_q <= pos_mem[pos_raddr];
  end

  // Sum memory.
  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_rd_q <= sum_mem[sum_raddr];
  end

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    comp_d      = comp_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(VERTICES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_d  = '0;
        comp_d = '0;
        if (accept) begin
          case (command_i)
            CMD_TRI: begin
              if (ca_ok && cb_ok && cc_ok) begin
                state_d = ST_POS;
              end
            end
            CMD_READ: begin
              state_d = vi_ok ? ST_SUM_RD : ST_OUT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_POS: begin
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(3)) begin
          cnt_d   = '0;
          state_d = ST_CROSS;
        end
      end
      ST_CROSS: begin
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(6)) begin
          cnt_d   = '0;
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (c_q[0] == '0 && c_q[1] == '0 && c_q[2] == '0) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (!norm_hi && !norm_lo) begin
          cnt_d   = '0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(3)) begin
          cnt_d   = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(P)) begin
          comp_d  = '0;
          state_d = ST_DIVI;
        end
      end
      ST_DIVI: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(F)) begin
          comp_d = comp_q + 2'd1;
          if (comp_q == 2'd2) begin
            comp_d  = '0;
            state_d = is_tri_q ? ST_RMW_RD : ST_OUT;
          end else begin
            state_d = ST_DIVI;
          end
        end
      end
      ST_RMW_RD: begin
        state_d = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        comp_d = comp_q + 2'd1;
        if (comp_q == 2'd2) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_RMW_RD;
        end
      end
      ST_SUM_RD: begin
        state_d = ST_SUM_LD;
      end
      ST_SUM_LD: begin
        state_d = (sum_rd_q == '0) ? ST_OUT : ST_NORM;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      comp_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      comp_q      <= comp_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cor_q[0] <= AW'(corner_a_i);
          cor_q[1] <= AW'(corner_b_i);
          cor_q[2] <= AW'(corner_c_i);
          vidx_q   <= AW'(vertex_index_i);
          is_tri_q <= (command_i == CMD_TRI);
          zf_q     <= 1'b1;
        end
      end
      ST_POS: begin
        // Read data is registered, so it arrives in the cycle after its address.
        if (cnt_q == CNTW'(1)) begin
          pa_q[0] <= pos_rd_q[3*POS_W-1:2*POS_W];
          pa_q[1] <= pos_rd_q[2*POS_W-1:POS_W];
          pa_q[2] <= pos_rd_q[POS_W-1:0];
        end
        if (cnt_q == CNTW'(2)) begin
          e1_q[0] <= EDGE_W'($signed(pos_rd_q[3*POS_W-1:2*POS_W])) - EDGE_W'(pa_q[0]);
          e1_q[1] <= EDGE_W'($signed(pos_rd_q[2*POS_W-1:POS_W])) - EDGE_W'(pa_q[1]);
          e1_q[2] <= EDGE_W'($signed(pos_rd_q[POS_W-1:0])) - EDGE_W'(pa_q[2]);
        end
        if (cnt_q == CNTW'(3)) begin
          e2_q[0] <= EDGE_W'($signed(pos_rd_q[3*POS_W-1:2*POS_W])) - EDGE_W'(pa_q[0]);
          e2_q[1] <= EDGE_W'($signed(pos_rd_q[2*POS_W-1:POS_W])) - EDGE_W'(pa_q[1]);
          e2_q[2] <= EDGE_W'($signed(pos_rd_q[POS_W-1:0])) - EDGE_W'(pa_q[2]);
          c_q[0]  <= '0;
          c_q[1]  <= '0;
          c_q[2]  <= '0;
        end
      end
      ST_CROSS: begin
        // Each component gets a product added and then one subtracted.
        if (cnt_q != CNTW'(0)) begin
          case (cnt_prev[2:1])
            2'd0: c_q[0] <= cnt_prev[0] ? c_q[0] - CRS_W'(prod_q) : c_q[0] + CRS_W'(prod_q);
            2'd1: c_q[1] <= cnt_prev[0] ? c_q[1] - CRS_W'(prod_q) : c_q[1] + CRS_W'(prod_q);
            default: c_q[2] <= cnt_prev[0] ? c_q[2] - CRS_W'(prod_q)
                                           : c_q[2] + CRS_W'(prod_q);
          endcase
        end
      end
      ST_SIGN: begin
        mag_q[0] <= crs_mag(c_q[0]);
        mag_q[1] <= crs_mag(c_q[1]);
        mag_q[2] <= crs_mag(c_q[2]);
        sgn_q[0] <= c_q[0][CRS_W-1];
        sgn_q[1] <= c_q[1][CRS_W-1];
        sgn_q[2] <= c_q[2][CRS_W-1];
        zf_q     <= 1'b0;
      end
      ST_SUM_LD: begin
        mag_q[0] <= sum_mag(sum_rd_q[3*SUM_W-1:2*SUM_W]);
        mag_q[1] <= sum_mag(sum_rd_q[2*SUM_W-1:SUM_W]);
        mag_q[2] <= sum_mag(sum_rd_q[SUM_W-1:0]);
        sgn_q[0] <= sum_rd_q[3*SUM_W-1];
        sgn_q[1] <= sum_rd_q[2*SUM_W-1];
        sgn_q[2] <= sum_rd_q[SUM_W-1];
        zf_q     <= (sum_rd_q == '0);
      end
      ST_NORM: begin
        // Shift all magnitudes together until the largest has its top bit at P-1.
        if (norm_hi) begin
          mag_q[0] <= mag_q[0] >> 1;
          mag_q[1] <= mag_q[1] >> 1;
          mag_q[2] <= mag_q[2] >> 1;
        end else if (norm_lo) begin
          mag_q[0] <= mag_q[0] << 1;
          mag_q[1] <= mag_q[1] << 1;
          mag_q[2] <= mag_q[2] << 1;
        end else begin
          rad_q    <= '0;
          sq_rem_q <= '0;
          root_q   <= '0;
        end
      end
      ST_SQ: begin
        if (cnt_q != CNTW'(0)) begin
          rad_q <= rad_q + LW'($unsigned(prod_q));
        end
      end
      ST_SQRT: begin
        rad_q  <= rad_q << 2;
        root_q <= {root_q[RTW-2:0], sq_take};
        if (sq_take) begin
          sq_rem_q <= sq_rem_n - sq_trial;
        end else begin
          sq_rem_q <= sq_rem_n;
        end
      end
      ST_DIVI: begin
        div_rem_q <= DRW'(numer >> QW);
        nlo_q     <= numer[QW-1:0];
        quo_q     <= '0;
      end
      ST_DIV: begin
        nlo_q <= nlo_q << 1;
        quo_q <= quo_n;
        if (div_take) begin
          div_rem_q <= div_rem_n - DRW'(root_q);
        end else begin
          div_rem_q <= div_rem_n;
        end
        if (cnt_q == CNTW'(F)) begin
          case (comp_q)
            2'd0: res_q[0] <= sgn_q[0] ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
            2'd1: res_q[1] <= sgn_q[1] ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
            default: res_q[2] <= sgn_q[2] ? -$signed({1'b0, quo_n})
                                          : $signed({1'b0, quo_n});
          endcase
        end
      end
      default: begin
        zf_q <= zf_q;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      if (zf_q) begin
        nx_q <= '0;
        ny_q <= '0;
        nz_q <= '0;
      end else begin
        nx_q <= NRM_W'(res_q[0]);
        ny_q <= NRM_W'(res_q[1]);
        nz_q <= NRM_W'(res_q[2]);
      end
      zs_q <= zf_q;
    end
  end

endmodule

/* dv/tb_vertex_normal_accumulator.sv */
// ----------------------------------------------------------------------------
// Vertex normal accumulator testbench
// Drives store, triangle, read and unused-command words with random idling on both channels,
// keeps its own fixed-point model of positions and per-vertex sums, and
// checks every returned normal word against the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_vertex_normal_accumulator;
  import vna_pkg::*;

  localparam int unsigned NVERT    = 1024;
  localparam int unsigned FRAC     = 14;
  localparam int unsigned PREC     = FRAC + 8;
  localparam logic [1:0]  CMD_NONE = 2'd3;
  localparam int          SUM_HI   = 8388607;
  localparam int          SUM_LO   = -8388608;
  localparam int          POOL_N   = 20;

  typedef struct packed {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic                    zero;
  } normal_word_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_r = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              command_r = CMD_STORE;
  logic [IDX_W-1:0]        vertex_index_r = '0;
  logic signed [POS_W-1:0] pos_x_r = '0;
  logic signed [POS_W-1:0] pos_y_r = '0;
  logic signed [POS_W-1:0] pos_z_r = '0;
  logic [IDX_W-1:0]        corner_a_r = '0;
  logic [IDX_W-1:0]        corner_b_r = '0;
  logic [IDX_W-1:0]        corner_c_r = '0;
  logic                    out_valid_o;
  logic                    out_ready_r = 1'b0;
  logic signed [NRM_W-1:0] normal_x_o;
  logic signed [NRM_W-1:0] normal_y_o;
  logic signed [NRM_W-1:0] normal_z_o;
  logic                    zero_sum_o;

  // Model state: positions and saturating per-vertex sums.
  logic signed [POS_W-1:0] pos_mem [NVERT][3];
  int                      sum_mem [NVERT][3];
  normal_word_t            normal_q [$];
  int                      n_errors = 0;
  bit                      no_idle = 1'b0;
  int                      hold_reqs = 0;
  int                      hold_done = 0;
  int                      hold_len = 0;
  int                      pool [POOL_N];

  always #4 clk_i = ~clk_i;

  vertex_normal_accumulator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_r),
    .in_ready_o    (in_ready_o),
    .command_i     (command_r),
    .vertex_index_i(vertex_index_r),
    .pos_x_i       (pos_x_r),
    .pos_y_i       (pos_y_r),
    .pos_z_i       (pos_z_r),
    .corner_a_i    (corner_a_r),
    .corner_b_i    (corner_b_r),
    .corner_c_i    (corner_c_r),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_r),
    .normal_x_o    (normal_x_o),
    .normal_y_o    (normal_y_o),
    .normal_z_o    (normal_z_o),
    .zero_sum_o    (zero_sum_o)
  );

  // Integer square root, digit by digit.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Scale a vector to unit length with FRAC fraction bits; returns 0 for zero.
  function automatic bit unit_vector(input longint c0, input longint c1, input longint c2,
                                     output longint q0, output longint q1,
                                     output longint q2);
    longint          c [3];
    longint          q [3];
    longint unsigned mag [3];
    longint unsigned m;
    longint unsigned len2;
    longint unsigned r;
    longint unsigned v;
    c[0] = c0; c[1] = c1; c[2] = c2;
    m = 0;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
      if (mag[i] > m) m = mag[i];
      q[i] = 0;
    end
    q0 = 0; q1 = 0; q2 = 0;
    if (m == 0) return 1'b0;
    while (m >= (64'd1 << PREC)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << (PREC - 1))) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    for (int i = 0; i < 3; i++) len2 += mag[i] * mag[i];
    r = int_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      v    = ((mag[i] << FRAC) + (r >> 1)) / r;
      q[i] = (c[i] < 0) ? -longint'(v) : longint'(v);
    end
    q0 = q[0]; q1 = q[1]; q2 = q[2];
    return 1'b1;
  endfunction

  // Update the mesh model for one accepted word and queue any normal it returns.
  function automatic void apply_word(input logic [1:0] cmd, input int vi,
                                     input logic signed [POS_W-1:0] px,
                                     input logic signed [POS_W-1:0] py,
                                     input logic signed [POS_W-1:0] pz,
                                     input int ca, input int cb, input int cc);
    longint       e1 [3];
    longint       e2 [3];
    longint       q [3];
    longint       t;
    int           corner [3];
    bit           nz;
    normal_word_t w;
    case (cmd)
      CMD_STORE: begin
        pos_mem[vi][0] = px;
        pos_mem[vi][1] = py;
        pos_mem[vi][2] = pz;
        for (int i = 0; i < 3; i++) sum_mem[vi][i] = 0;
      end
      CMD_TRI: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = longint'(pos_mem[cb][i]) - longint'(pos_mem[ca][i]);
          e2[i] = longint'(pos_mem[cc][i]) - longint'(pos_mem[ca][i]);
        end
        if (unit_vector(e1[1] * e2[2] - e1[2] * e2[1], e1[2] * e2[0] - e1[0] * e2[2],
                        e1[0] * e2[1] - e1[1] * e2[0], q[0], q[1], q[2])) begin
          corner[0] = ca; corner[1] = cb; corner[2] = cc;
          for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
              t = longint'(sum_mem[corner[k]][i]) + q[i];
              if (t > SUM_HI) t = SUM_HI;
              if (t < SUM_LO) t = SUM_LO;
              sum_mem[corner[k]][i] = int'(t);
            end
          end
        end
      end
      CMD_READ: begin
        nz     = unit_vector(sum_mem[vi][0], sum_mem[vi][1], sum_mem[vi][2],
                             q[0], q[1], q[2]);
        w.nx   = q[0][NRM_W-1:0];
        w.ny   = q[1][NRM_W-1:0];
        w.nz   = q[2][NRM_W-1:0];
        w.zero = !nz;
        normal_q = {normal_q, w};
      end
      default: ;
    endcase
  endfunction

  // Offer one word, after an optional random gap, and wait until it is taken.
  task automatic send_word(input logic [1:0] cmd, input int vi,
                           input logic signed [POS_W-1:0] px,
                           input logic signed [POS_W-1:0] py,
                           input logic signed [POS_W-1:0] pz,
                           input int ca, input int cb, input int cc);
    if (!no_idle && $urandom_range(99) < 13) begin
      in_valid_r <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_r     <= 1'b1;
    command_r      <= cmd;
    vertex_index_r <= vi[IDX_W-1:0];
    pos_x_r        <= px;
    pos_y_r        <= py;
    pos_z_r        <= pz;
    corner_a_r     <= ca[IDX_W-1:0];
    corner_b_r     <= cb[IDX_W-1:0];
    corner_c_r     <= cc[IDX_W-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    apply_word(cmd, vi, px, py, pz, ca, cb, cc);
  endtask

  task automatic store_vertex(input int vi, input int px, input int py, input int pz);
    send_word(CMD_STORE, vi, px[POS_W-1:0], py[POS_W-1:0], pz[POS_W-1:0],
              $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
  endtask

  task automatic add_triangle(input int ca, input int cb, input int cc);
    send_word(CMD_TRI, $urandom_range(1023), 16'($urandom), 16'($urandom), 16'($urandom),
              ca, cb, cc);
  endtask

  task automatic read_normal(input int vi);
    send_word(CMD_READ, vi, 16'($urandom), 16'($urandom), 16'($urandom),
              $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
  endtask

  // Sender pause: hold valid low until every expected normal has come back.
  task automatic wait_drained();
    in_valid_r <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk_i);
  endtask

  // Extreme positions, degenerate triangles, unwritten reads, unused command.
  task automatic test_directed();
    store_vertex(1023, 32767, 32767, 32767);
    store_vertex(512, -32768, 32767, 0);
    store_vertex(1, 0, 0, 0);
    store_vertex(2, 100, 100, 100);
    store_vertex(3, 200, 200, 200);
    store_vertex(0, -32768, -32768, -32768);
    add_triangle(1023, 512, 1);
    add_triangle(0, 512, 1023);
    add_triangle(1, 1, 2);
    add_triangle(1, 2, 3);
    add_triangle(2, 2, 2);
    read_normal(1023);
    read_normal(512);
    read_normal(1);
    read_normal(2);
    read_normal(700);
    send_word(CMD_NONE, 1023, 16'h7fff, 16'h8000, 16'h4000, 1023, 512, 0);
    read_normal(0);
    store_vertex(1023, 5, -7, 9);
    read_normal(1023);
    wait_drained();
  endtask

  // Repeated face normals pile up in their corners, then partly cancel.
  task automatic test_accumulate();
    store_vertex(4, 0, 0, 0);
    store_vertex(5, 16384, 0, 0);
    store_vertex(6, 0, 16384, 0);
    for (int i = 0; i < 6; i++) add_triangle(4, 5, 6);
    read_normal(4);
    for (int i = 0; i < 3; i++) add_triangle(4, 6, 5);
    read_normal(5);
    read_normal(6);
    wait_drained();
  endtask

  // Receiver holds off while reads pile up, so the input must stall.
  task automatic test_backpressure();
    hold_reqs++;
    for (int i = 0; i < 8; i++) begin
      read_normal(pool[i]);
      add_triangle(pool[i], pool[i + 1], pool[i + 2]);
    end
    wait_drained();
  endtask

  // Random mesh traffic over a small pool of stored vertices.
  task automatic test_random();
    int sel;
    int k;
    for (int n = 0; n < 380; n++) begin
      no_idle = (n >= 120 && n < 200);
      sel = $urandom_range(99);
      if (sel < 15) begin
        k = $urandom_range(POOL_N - 1);
        pool[k] = $urandom_range(1023);
        store_vertex(pool[k], 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (sel < 68) begin
        add_triangle(pool[$urandom_range(POOL_N - 1)], pool[$urandom_range(POOL_N - 1)],
                     pool[$urandom_range(POOL_N - 1)]);
      end else if (sel < 95) begin
        read_normal(($urandom_range(9) == 0) ? $urandom_range(1023)
                                              : pool[$urandom_range(POOL_N - 1)]);
      end else begin
        send_word(CMD_NONE, $urandom_range(1023), 16'($urandom), 16'($urandom),
                  16'($urandom), $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(1023));
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver: random ready, with a long hold-off counted here when requested.
  always @(posedge clk_i) begin
    if (hold_reqs != hold_done) begin
      hold_done   <= hold_reqs;
      hold_len    <= 399;
      out_ready_r <= 1'b0;
    end else if (hold_len != 0) begin
      out_ready_r <= 1'b0;
      hold_len    <= hold_len - 1;
    end else begin
      out_ready_r <= no_idle || ($urandom_range(99) >= 13);
    end
  end

  // Compare each accepted normal word with the oldest prediction.
  always @(posedge clk_i) begin
    normal_word_t w;
    if (rst_ni && out_valid_o && out_ready_r) begin
      if (normal_q.size() == 0) begin
        $error("normal word with none expected");
        n_errors++;
      end else begin
        w = normal_q.pop_front();
        if (normal_x_o !== w.nx) begin
          $error("normal_x: expected %0d, got %0d", w.nx, normal_x_o);
          n_errors++;
        end
        if (normal_y_o !== w.ny) begin
          $error("normal_y: expected %0d, got %0d", w.ny, normal_y_o);
          n_errors++;
        end
        if (normal_z_o !== w.nz) begin
          $error("normal_z: expected %0d, got %0d", w.nz, normal_z_o);
          n_errors++;
        end
        if (zero_sum_o !== w.zero) begin
          $error("zero_sum: expected %0d, got %0d", w.zero, zero_sum_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    for (int v = 0; v < NVERT; v++) begin
      for (int i = 0; i < 3; i++) begin
        pos_mem[v][i] = '0;
        sum_mem[v][i] = 0;
      end
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_accumulate();
    // Fill the random pool with stored vertices first.
    for (int k = 0; k < POOL_N; k++) begin
      pool[k] = $urandom_range(1023);
      store_vertex(pool[k], 16'($urandom), 16'($urandom), 16'($urandom));
    end
    test_backpressure();
    test_random();
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (n_errors == 0 && normal_q.size() == 0) begin
      $display("PASS vertex_normal_accumulator");
    end else begin
      $display("FAIL vertex_normal_accumulator");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL vertex_normal_accumulator");
    $finish;
  end

endmodule
